@@ rtl/core/ssc_pkg.sv @@
// Shared types and constants for the sensor-to-servo slew control block.
`timescale 1ns / 1ps

package ssc_pkg;

  localparam int SENSOR_BITS = 12;
  localparam int POS_BITS    = 11;
  localparam int PULSE_BITS  = 16;
  localparam int SCALE_BITS  = 14;
  localparam int CFG_BITS    = 16;
  localparam int INDEX_BITS  = 2;

  localparam logic [POS_BITS-1:0]   NEUTRAL     = 11'd1500;
  localparam logic [SCALE_BITS-1:0] DRIVE_SCALE = 14'd12000;

  localparam logic [PULSE_BITS-1:0] RESET_ENABLE_THRESHOLD = 16'd4000;
  localparam logic [POS_BITS-1:0]   RESET_SLEW_STEP        = 11'd50;
  localparam logic [11:0]           RESET_VALID_LIMIT      = 12'd455;

  typedef enum logic [INDEX_BITS-1:0] {
    CFG_ENABLE_THRESHOLD = 2'd0,
    CFG_SLEW_STEP        = 2'd1,
    CFG_VALID_LIMIT      = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic                  we;
    logic [INDEX_BITS-1:0] index;
    logic [CFG_BITS-1:0]   data;
  } ssc_cfg_t;

  typedef struct packed {
    logic [SENSOR_BITS-1:0] sensor_one;
    logic [SENSOR_BITS-1:0] sensor_two;
    logic [PULSE_BITS-1:0]  switch_pulse;
    logic [PULSE_BITS-1:0]  remote_left;
    logic [PULSE_BITS-1:0]  remote_right;
  } ssc_in_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    logic                  on;
    logic                  valid;
    logic                  update;
    logic [POS_BITS-1:0]   drive;
    logic [PULSE_BITS-1:0] remote_left;
    logic [PULSE_BITS-1:0] remote_right;
  } ssc_cls_t;

  typedef struct packed {
    logic [POS_BITS-1:0]   flap_left_cmp;
    logic [POS_BITS-1:0]   flap_right_cmp;
    logic [PULSE_BITS-1:0] canard_left_cmp;
    logic [PULSE_BITS-1:0] canard_right_cmp;
    logic                  system_on;
    logic                  sensor_valid;
  } ssc_out_t;

endpackage

@@ rtl/core/ssc_queue.sv @@
// Small register-based first-in first-out queue.
`timescale 1ns / 1ps

module ssc_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CntW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/core/ssc_front.sv @@
// Front end: folds the sensor codes, qualifies the request and computes the drive.
`timescale 1ns / 1ps

module ssc_front
  import ssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ssc_cfg_t cfg,
  input  ssc_in_t  item,
  output ssc_cls_t cls
);

  localparam logic [SENSOR_BITS:0] FullCode = (SENSOR_BITS + 1)'(1) << SENSOR_BITS;
  localparam int ProdW = SENSOR_BITS + SCALE_BITS;

  logic [PULSE_BITS-1:0]  enable_threshold;
  logic [11:0]            valid_limit;
  logic [SENSOR_BITS-1:0] fold_one;
  logic [SENSOR_BITS-1:0] fold_two;
  logic [SENSOR_BITS:0]   diff_one;
  logic [SENSOR_BITS:0]   diff_two;
  logic [SENSOR_BITS-1:0] value;
  logic [ProdW-1:0]       product;
  logic [SCALE_BITS-1:0]  scaled;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable_threshold <= RESET_ENABLE_THRESHOLD;
      valid_limit      <= RESET_VALID_LIMIT;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_ENABLE_THRESHOLD: enable_threshold <= cfg.data;
        CFG_VALID_LIMIT:      valid_limit      <= cfg.data[11:0];
        default:              ;
      endcase
    end
  end

  // Codes at or above mid-scale fold back; the top bit marks such a code.
  always_comb begin
    diff_one = FullCode - {1'b0, item.sensor_one};
    diff_two = FullCode - {1'b0, item.sensor_two};
    fold_one = item.sensor_one[SENSOR_BITS-1] ? diff_one[SENSOR_BITS-1:0] : item.sensor_one;
    fold_two = item.sensor_two[SENSOR_BITS-1] ? diff_two[SENSOR_BITS-1:0] : item.sensor_two;
    value    = (fold_one < fold_two) ? fold_one : fold_two;
    product  = ProdW'(value) * ProdW'(DRIVE_SCALE);
    scaled   = product[ProdW-1:SENSOR_BITS];

    cls.on           = item.switch_pulse < enable_threshold;
    cls.valid        = value <= valid_limit;
    cls.update       = item.sensor_one[SENSOR_BITS-1] && !item.sensor_two[SENSOR_BITS-1];
    cls.drive        = (scaled > SCALE_BITS'(NEUTRAL)) ? NEUTRAL : scaled[POS_BITS-1:0];
    cls.remote_left  = item.remote_left;
    cls.remote_right = item.remote_right;
  end

endmodule

@@ rtl/core/ssc_back.sv @@
// Back end: target update, per-channel slewing and canard compare sums.
`timescale 1ns / 1ps

module ssc_back
  import ssc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  ssc_cfg_t cfg,
  input  logic     fire,
  input  ssc_cls_t cls,
  output ssc_out_t result
);

  logic [POS_BITS-1:0] slew_step;
  logic [POS_BITS-1:0] target [4];
  logic [POS_BITS-1:0] current [4];
  logic [POS_BITS-1:0] target_next [4];
  logic [POS_BITS-1:0] current_next [4];
  logic [PULSE_BITS:0] sum_left;
  logic [PULSE_BITS:0] sum_right;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      target_next[i] = target[i];
    end
    if (!(cls.on && cls.valid)) begin
      target_next[0] = NEUTRAL;
      target_next[1] = NEUTRAL;
      target_next[2] = '0;
      target_next[3] = '0;
    end else if (cls.update) begin
      target_next[0] = NEUTRAL - cls.drive;
      target_next[1] = NEUTRAL - cls.drive;
      target_next[2] = cls.drive;
      target_next[3] = cls.drive;
    end

    // Each position steps toward its target and lands on it when close enough.
    for (int i = 0; i < 4; i++) begin
      if (current[i] < target_next[i]) begin
        current_next[i] = (target_next[i] - current[i] > slew_step) ?
                          current[i] + slew_step : target_next[i];
      end else if (current[i] > target_next[i]) begin
        current_next[i] = (current[i] - target_next[i] > slew_step) ?
                          current[i] - slew_step : target_next[i];
      end else begin
        current_next[i] = current[i];
      end
    end

    sum_left  = {1'b0, cls.remote_left} + (PULSE_BITS + 1)'(current_next[2]);
    sum_right = {1'b0, cls.remote_right} + (PULSE_BITS + 1)'(current_next[3]);

    result.flap_left_cmp    = current_next[0];
    result.flap_right_cmp   = current_next[1];
    result.canard_left_cmp  = sum_left[PULSE_BITS] ? '1 : sum_left[PULSE_BITS-1:0];
    result.canard_right_cmp = sum_right[PULSE_BITS] ? '1 : sum_right[PULSE_BITS-1:0];
    result.system_on        = cls.on;
    result.sensor_valid     = cls.valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_step <= RESET_SLEW_STEP;
      for (int i = 0; i < 4; i++) begin
        target[i]  <= '0;
        current[i] <= '0;
      end
    end else begin
      if (cfg.we && cfg.index == CFG_SLEW_STEP) begin
        slew_step <= cfg.data[POS_BITS-1:0];
      end
      if (fire) begin
        for (int i = 0; i < 4; i++) begin
          target[i]  <= target_next[i];
          current[i] <= current_next[i];
        end
      end
    end
  end

endmodule

@@ rtl/core/sensor_to_servo_slew_control.sv @@
// Top level of the sensor-to-servo slew control block.
`timescale 1ns / 1ps

// One request per control tick carries two sensor codes, the mode-switch pulse and two
// remote pulses; it yields exactly one result with four servo compare values and two
// status flags. The block takes one request per clock cycle while its request queue is
// not full, and returns one result per cycle when results are popped as fast. The front
// end classifies each request combinationally; the request queue of QUEUE_DEPTH entries
// registers it, the back end updates the servo state once per request and writes a
// second queue that holds results until they are popped. The four servo positions and
// their targets are the only state carried from one request to the next, all updated
// together when the back end takes a request. Configuration writes take effect at the
// next edge and are meant to be made while no request is in flight.
module sensor_to_servo_slew_control
  import ssc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  output logic                  full,
  input  ssc_in_t               item,
  output logic                  empty,
  input  logic                  pop,
  output ssc_out_t              result,
  input  logic                  cfg_we,
  input  logic [INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  ssc_cfg_t cfg;
  ssc_cls_t cls_in;
  ssc_cls_t cls_out;
  ssc_out_t back_result;
  logic     cq_empty;
  logic     oq_full;
  logic     back_fire;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  assign back_fire = !cq_empty && !oq_full;

  ssc_front u_front (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .item (item),
    .cls  (cls_in)
  );

  ssc_queue #(
    .WIDTH ($bits(ssc_cls_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_cls_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (cls_in),
    .full    (full),
    .pop     (back_fire),
    .rd_data (cls_out),
    .empty   (cq_empty)
  );

  ssc_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (back_fire),
    .cls    (cls_out),
    .result (back_result)
  );

  ssc_queue #(
    .WIDTH ($bits(ssc_out_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_out_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (back_fire),
    .wr_data (back_result),
    .full    (oq_full),
    .pop     (pop),
    .rd_data (result),
    .empty   (empty)
  );

  // The back end only advances the servo state when its result has somewhere to go.
  a_fire_has_room: assert property (@(posedge clk) disable iff (rst)
    back_fire |-> !oq_full && !cq_empty)
    else $error("back end advanced without a request or without result space");

  // Flap positions never pass neutral.
  a_flap_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> result.flap_left_cmp <= NEUTRAL && result.flap_right_cmp <= NEUTRAL)
    else $error("flap compare value beyond neutral");

  // A full request queue that is not drained stays full.
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    full && !back_fire |=> full)
    else $error("request queue lost an entry without the back end taking it");

endmodule
